@@ design/gfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Greyscale framebuffer refresh package
// Panel geometry, display command bytes, byte conversion tables and the
// command/status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package gfr_pkg;

    // Panel geometry
    localparam int PANEL_ROWS    = 160;
    localparam int BYTES_PER_ROW = 60;
    localparam int PAD_BYTES     = 8;

    localparam int PANEL_COLS   = BYTES_PER_ROW * 4;
    localparam int STORE_SIZE   = PANEL_ROWS * BYTES_PER_ROW;
    localparam int PREAMBLE_LEN = 14;
    localparam int ROW_STEPS    = PAD_BYTES + 2 * BYTES_PER_ROW;

    // Derived widths
    localparam int ADDR_W  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int ROW_W   = $clog2(PANEL_ROWS + 1);
    localparam int COL_W   = $clog2(ROW_STEPS);
    localparam int PRE_W   = $clog2(PREAMBLE_LEN + 1);
    localparam int COORD_W = 9;
    localparam int MUL_W   = ADDR_W + COORD_W;

    // Display command and data bytes
    localparam logic [7:0] CMD_COL_ADDR   = 8'h2A;
    localparam logic [7:0] COL_END        = 8'h7F;
    localparam logic [7:0] CMD_ROW_ADDR   = 8'h2B;
    localparam logic [7:0] ROW_END        = 8'h9F;
    localparam logic [7:0] CMD_START_LINE = 8'h37;
    localparam logic [7:0] CMD_MODE       = 8'h38;
    localparam logic [7:0] CMD_RAM_WRITE  = 8'h2C;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h29;
    localparam logic [7:0] DATA_ZERO      = 8'h00;
    localparam logic [7:0] PAD_FILL       = 8'hFF;
    localparam logic [1:0] PIXEL_MASK     = 2'h3;

    // Preamble entry that carries the grey mode bit
    localparam int PRE_MODE_STEP = 12;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_BOX   = 2'd1,
        KIND_START = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    // One byte on the display bus
    typedef struct packed {
        logic       is_data;
        logic [7:0] data;
    } t_lcd_byte;

    localparam t_lcd_byte PRE_TABLE [PREAMBLE_LEN] = '{
        '{1'b0, CMD_COL_ADDR},
        '{1'b1, DATA_ZERO},
        '{1'b1, DATA_ZERO},
        '{1'b1, DATA_ZERO},
        '{1'b1, COL_END},
        '{1'b0, CMD_ROW_ADDR},
        '{1'b1, DATA_ZERO},
        '{1'b1, DATA_ZERO},
        '{1'b1, DATA_ZERO},
        '{1'b1, ROW_END},
        '{1'b0, CMD_START_LINE},
        '{1'b1, DATA_ZERO},
        '{1'b0, CMD_MODE},
        '{1'b0, CMD_RAM_WRITE}
    };

    localparam logic [7:0] HI_PART [4] = '{8'h00, 8'h40, 8'h80, 8'hE0};
    localparam logic [7:0] LO_PART [4] = '{8'h00, 8'h08, 8'h10, 8'h1C};

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;
        logic pix_rd;
        logic box_load;
        logic box_rd;
        logic mem_wr;
        logic box_adv;
        logic refresh_start;
        logic tick_rd;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic in_on_panel;
        logic box_empty;
        logic box_on_panel;
        logic box_last;
        logic active;
        logic tick_needs_read;
        logic out_free;
    } t_dp_stat;

    // Preamble byte for a step; the mode command picks up the grey bit
    function automatic t_lcd_byte preamble_byte(input logic [PRE_W-1:0] step,
                                                input logic grey);
        t_lcd_byte e;
        e = '{is_data: 1'b1, data: DATA_ZERO};
        if (int'(step) < PREAMBLE_LEN) begin
            e = PRE_TABLE[step];
        end
        if (int'(step) == PRE_MODE_STEP) begin
            e.data = e.data | {7'd0, grey};
        end
        return e;
    endfunction

    // Left pixel pair of a store byte, inverted for the panel
    function automatic logic [7:0] first_byte(input logic [7:0] b);
        return ~(HI_PART[b[5:4]] | LO_PART[b[7:6]]);
    endfunction

    // Right pixel pair of a store byte, inverted for the panel
    function automatic logic [7:0] second_byte(input logic [7:0] b);
        return ~(HI_PART[b[1:0]] | LO_PART[b[3:2]]);
    endfunction

endpackage

@@ design/gfr_ifs.sv @@
// ----------------------------------------------------------------------------
// Greyscale framebuffer refresh channels
// Valid/ready channels for drawing items and for display bus bytes.
// ----------------------------------------------------------------------------
interface gfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] box_width;
    logic [7:0] box_height;
    logic [1:0] shade;

    modport source (
        output valid, kind, x, y, box_width, box_height, shade,
        input  ready
    );
    modport sink (
        input  valid, kind, x, y, box_width, box_height, shade,
        output ready
    );
endinterface

interface gfr_out_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;

    modport source (
        output valid, is_data, out_byte, last,
        input  ready
    );
    modport sink (
        input  valid, is_data, out_byte, last,
        output ready
    );
endinterface

@@ design/gfr_dp.sv @@
// ----------------------------------------------------------------------------
// Greyscale framebuffer refresh datapath
// Pixel store, address generation, read-modify-write merge, box walker,
// refresh sequencing counters and the output register.
// ----------------------------------------------------------------------------
module gfr_dp import gfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  logic [7:0] i_box_width,
    input  logic [7:0] i_box_height,
    input  logic [1:0] i_shade,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_out_ready,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    output logic       o_is_data,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    // Pixel store
    logic [7:0]        mem [STORE_SIZE];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [1:0]        r_wr_pos;
    logic [1:0]        r_shade;
    logic [ADDR_W-1:0] r_clr_addr;

    // Box walker
    logic [7:0]         r_box_x;
    logic [7:0]         r_box_w;
    logic [7:0]         r_box_h;
    logic [7:0]         r_box_i;
    logic [7:0]         r_box_j;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;

    // Refresh sequencing
    logic             r_grey;
    logic             r_active;
    logic [PRE_W-1:0] r_pre_step;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [7:0]       r_held;

    // Output register
    logic       r_out_valid;
    logic       r_out_is_data;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic [MUL_W-1:0]   mul_row;
    logic [MUL_W-1:0]   mul_off;
    logic [MUL_W-1:0]   rd_addr_full;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic [2:0]         mask_sh;
    logic [7:0]         merged;
    logic [COL_W-1:0]   tick_k;
    logic               pre_done;
    logic               rows_left;
    logic               in_pad;
    logic               box_col_end;
    t_lcd_byte          pre_e;
    logic               res_is_data;
    logic [7:0]         res_byte;
    logic               res_last;

    // Pick the pixel being addressed: the new item or the box walker
    always_comb begin
        if (i_cmd.box_rd) begin
            pix_col = r_cx;
            pix_row = r_cy;
        end else begin
            pix_col = {1'b0, i_x};
            pix_row = {1'b0, i_y};
        end
    end

    // Form the store address: row times row pitch plus byte offset
    assign tick_k = r_col - COL_W'(PAD_BYTES);

    always_comb begin
        if (i_cmd.tick_rd) begin
            mul_row = MUL_W'(r_row);
            mul_off = MUL_W'(tick_k >> 1);
        end else begin
            mul_row = MUL_W'(pix_row);
            mul_off = MUL_W'(pix_col >> 2);
        end
        rd_addr_full = mul_row * MUL_W'(BYTES_PER_ROW) + mul_off;
        rd_addr      = rd_addr_full[ADDR_W-1:0];
    end

    // Merge the new shade into the byte read back
    always_comb begin
        mask_sh = {~r_wr_pos, 1'b0};
        merged  = (r_rd_data & ~({6'd0, PIXEL_MASK} << mask_sh))
                | ({6'd0, r_shade} << mask_sh);
    end

    assign rd_en   = i_cmd.pix_rd | i_cmd.box_rd | i_cmd.tick_rd;
    assign wr_en   = i_cmd.clr_wr | i_cmd.mem_wr;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_wr_addr;
    assign wr_data = i_cmd.clr_wr ? PAD_FILL : merged;

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Advance the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Hold the pixel under modification
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_rd || i_cmd.box_rd) begin
            r_wr_addr <= rd_addr;
            r_wr_pos  <= pix_col[1:0];
        end
        if (i_cmd.pix_rd || i_cmd.box_load) begin
            r_shade <= i_shade;
        end
    end

    // Walk the box row by row
    assign box_col_end = (r_box_i == r_box_w - 8'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.box_load) begin
            r_box_x <= i_x;
            r_box_w <= i_box_width;
            r_box_h <= i_box_height;
            r_box_i <= 8'd0;
            r_box_j <= 8'd0;
            r_cx    <= {1'b0, i_x};
            r_cy    <= {1'b0, i_y};
        end else if (i_cmd.box_adv) begin
            if (box_col_end) begin
                r_box_i <= 8'd0;
                r_cx    <= {1'b0, r_box_x};
                r_box_j <= r_box_j + 8'd1;
                r_cy    <= r_cy + 1'b1;
            end else begin
                r_box_i <= r_box_i + 8'd1;
                r_cx    <= r_cx + 1'b1;
            end
        end
    end

    // Hold the grey mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grey <= 1'b0;
        end else if (i_cfg_we) begin
            r_grey <= i_cfg_data;
        end
    end

    // Build the next transfer byte
    assign pre_done  = (r_pre_step == PRE_W'(PREAMBLE_LEN));
    assign rows_left = (r_row < ROW_W'(PANEL_ROWS));
    assign in_pad    = (r_col < COL_W'(PAD_BYTES));
    assign pre_e     = preamble_byte(r_pre_step, r_grey);

    always_comb begin
        res_is_data = 1'b1;
        res_byte    = PAD_FILL;
        res_last    = 1'b0;
        if (!pre_done) begin
            res_is_data = pre_e.is_data;
            res_byte    = pre_e.data;
        end else if (rows_left) begin
            if (in_pad) begin
                res_byte = PAD_FILL;
            end else if (!tick_k[0]) begin
                res_byte = first_byte(r_rd_data);
            end else begin
                res_byte = r_held;
            end
        end else begin
            res_is_data = 1'b0;
            res_byte    = CMD_DISPLAY_ON;
            res_last    = 1'b1;
        end
    end

    // Advance the transfer position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_pre_step <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_held     <= 8'd0;
        end else if (i_cmd.refresh_start) begin
            r_active   <= 1'b1;
            r_pre_step <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_held     <= 8'd0;
        end else if (i_cmd.emit) begin
            if (!pre_done) begin
                r_pre_step <= r_pre_step + 1'b1;
            end else if (rows_left) begin
                if (!in_pad && !tick_k[0]) begin
                    r_held <= second_byte(r_rd_data);
                end
                if (r_col == COL_W'(ROW_STEPS - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else begin
                r_active   <= 1'b0;
                r_pre_step <= '0;
                r_row      <= '0;
                r_col      <= '0;
            end
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_is_data <= res_is_data;
            r_out_byte    <= res_byte;
            r_out_last    <= res_last;
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat.clr_done        = (r_clr_addr == ADDR_W'(STORE_SIZE - 1));
        o_stat.in_on_panel     = ({1'b0, i_x} < COORD_W'(PANEL_COLS))
                              && ({1'b0, i_y} < COORD_W'(PANEL_ROWS));
        o_stat.box_empty       = (i_box_width == 8'd0) || (i_box_height == 8'd0);
        o_stat.box_on_panel    = (r_cx < COORD_W'(PANEL_COLS))
                              && (r_cy < COORD_W'(PANEL_ROWS));
        o_stat.box_last        = box_col_end && (r_box_j == r_box_h - 8'd1);
        o_stat.active          = r_active;
        o_stat.tick_needs_read = r_active && pre_done && rows_left && !in_pad
                              && !tick_k[0];
        o_stat.out_free        = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_is_data   = r_out_is_data;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

@@ design/gfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Greyscale framebuffer refresh controller
// Sequences the clearing pass, pixel and box read-modify-writes, and the
// emission of transfer bytes.
// ----------------------------------------------------------------------------
module gfr_ctrl import gfr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_kind    i_kind,
    input  t_dp_stat i_stat,
    output logic     o_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PIX_WR,
        S_BOX_RD,
        S_BOX_WR,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   accept;

    assign accept  = i_valid && r_ready;
    assign o_ready = r_ready;

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PIXEL: begin
                            if (i_stat.in_on_panel) begin
                                o_cmd.pix_rd = 1'b1;
                                n_state      = S_PIX_WR;
                            end
                        end
                        KIND_BOX: begin
                            if (!i_stat.box_empty) begin
                                o_cmd.box_load = 1'b1;
                                n_state        = S_BOX_RD;
                            end
                        end
                        KIND_START: begin
                            o_cmd.refresh_start = 1'b1;
                        end
                        KIND_TICK: begin
                            if (i_stat.active) begin
                                o_cmd.tick_rd = i_stat.tick_needs_read;
                                n_state       = S_EMIT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PIX_WR: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_BOX_RD: begin
                if (i_stat.box_on_panel) begin
                    o_cmd.box_rd = 1'b1;
                    n_state      = S_BOX_WR;
                end else if (i_stat.box_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.box_adv = 1'b1;
                end
            end
            S_BOX_WR: begin
                o_cmd.mem_wr = 1'b1;
                if (i_stat.box_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.box_adv = 1'b1;
                    n_state       = S_BOX_RD;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

@@ design/greyscale_framebuffer_refresh.sv @@
// Pixel write: a store read, then the merged write; start refresh: taken directly in idle.
// Transfer tick: an optional store read, then the emit, which waits while the output register is still held.
// Box fill: a load, then a read and a merged write per on-panel pixel; a clipped one is skipped.
// The read-modify-write on the store sets these steps.
// Reset: synchronous; a clearing pass writes 0xFF to all STORE_SIZE bytes,
// one a cycle, with ready low until it completes.
// ----------------------------------------------------------------------------
// Greyscale framebuffer refresh
// Two-bit greyscale panel framebuffer with pixel writes, clipped box fills and
// a byte-by-byte display refresh transfer.
// ----------------------------------------------------------------------------
module greyscale_framebuffer_refresh import gfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gfr_in_if.sink      i_in,
    gfr_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence control
    gfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_kind  (t_kind'(i_in.kind)),
        .i_stat  (stat),
        .o_ready (i_in.ready),
        .o_cmd   (cmd)
    );

    // Store and transfer datapath
    gfr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_x          (i_in.x),
        .i_y          (i_in.y),
        .i_box_width  (i_in.box_width),
        .i_box_height (i_in.box_height),
        .i_shade      (i_in.shade),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (o_out.ready),
        .o_stat       (stat),
        .o_out_valid  (o_out.valid),
        .o_is_data    (o_out.is_data),
        .o_out_byte   (o_out.out_byte),
        .o_last       (o_out.last)
    );

`ifndef SYNTH
    // A pixel read is always followed by its merged write
    a_pix_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pix_rd |=> cmd.mem_wr)
        else $error("pixel read not followed by write");

    // Never overwrite a beat that has not been taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("emit into a held output register");

    // Store port users are mutually exclusive
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_wr, cmd.pix_rd, cmd.box_rd, cmd.tick_rd, cmd.mem_wr,
                  cmd.emit, cmd.box_load, cmd.refresh_start}))
        else $error("conflicting datapath commands");

    // No item is taken during the clearing pass
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> !i_in.ready)
        else $error("ready high during clearing pass");
`endif

endmodule
